// ===== src/dtt_pkg.sv =====
package dtt_pkg;

   // transaction kinds on the request channel
   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_ADJUST = 2'd1,
      KIND_DELETE = 2'd2,
      KIND_TICK   = 2'd3
   } kind_type;

   // control from the sequencer to the earliest-deadline picker
   typedef struct packed {
      logic clear;  // start of a new pass over the table
      logic valid;  // a deadline word arrives from the memory this cycle
      logic armed;  // the arriving entry holds a running timer
   } pick_ctl_type;

endpackage

// ===== src/dtt_pick.sv =====
module dtt_pick #(
   parameter int IDX_W     = 6,
   parameter int TIME_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dtt_pkg::pick_ctl_type     ctl,
   input  logic [IDX_W-1:0]          idx,
   input  logic [TIME_BITS-1:0]      data,
   input  logic [TIME_BITS-1:0]      now,
   output logic                      found,
   output logic [IDX_W-1:0]          best_idx
);

   logic                 found_ff;
   logic                 found_in;
   logic [IDX_W-1:0]     best_idx_ff;
   logic [IDX_W-1:0]     best_idx_in;
   logic [TIME_BITS-1:0] best_dl_ff;
   logic [TIME_BITS-1:0] best_dl_in;
   logic                 take;

   // strict less-than keeps the lower slot on equal deadlines
   assign take = ctl.valid && ctl.armed && (data <= now) &&
                 (!found_ff || (data < best_dl_ff));

   always_comb begin
      found_in    = found_ff;
      best_idx_in = best_idx_ff;
      best_dl_in  = best_dl_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in    = 1'b1;
         best_idx_in = idx;
         best_dl_in  = data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      best_idx_ff <= best_idx_in;
      best_dl_ff  <= best_dl_in;
   end

   assign found    = found_ff;
   assign best_idx = best_idx_ff;

endmodule

// ===== src/deadline_timer_table.sv =====
// channel   direction  handshake               payload
// req       in         req_valid / req_stall   req_kind, req_slot, req_time_value
// rsp       out        rsp_valid / rsp_stall   rsp_expired_slot, rsp_last
//
// add, adjust and delete are applied when accepted and make no pass over the table.
// a tick makes K+1 passes over the deadline memory, K the number of expired timers;
// each pass reads all ENTRIES = min(SLOTS, 64) entries in turn through one read port.
// reset is synchronous and disarms every timer at once; deadlines are not cleared.
// rsp_stall holds the result register; the next pass waits for it, req stalls during a tick.
module deadline_timer_table #(
   parameter int SLOTS     = 64,
   parameter int TIME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [5:0]  req_slot,
   input  logic [31:0] req_time_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_expired_slot,
   output logic        rsp_last
);

   localparam int ENTRIES = (SLOTS < 64) ? SLOTS : 64;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type            state_ff;
   state_type            state_in;
   logic [CNT_W-1:0]     cnt_ff;
   logic [CNT_W-1:0]     cnt_in;
   logic                 rd_vld_ff;
   logic                 rd_vld_in;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic [IDX_W-1:0]     rd_idx_in;
   logic [TIME_BITS-1:0] rd_data_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [TIME_BITS-1:0] now_in;
   logic [ENTRIES-1:0]   armed_ff;
   logic [ENTRIES-1:0]   armed_in;
   logic                 have_prev_ff;
   logic                 have_prev_in;
   logic [IDX_W-1:0]     prev_slot_ff;
   logic [IDX_W-1:0]     prev_slot_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [5:0]           rsp_slot_ff;
   logic [5:0]           rsp_slot_in;
   logic                 rsp_last_ff;
   logic                 rsp_last_in;

   logic [TIME_BITS-1:0] deadline_mem [ENTRIES];

   logic                  req_acc;
   logic                  slot_ok;
   logic [IDX_W-1:0]      wr_idx;
   logic [TIME_BITS-1:0]  req_time;
   logic                  mem_we;
   logic                  mem_re;
   logic                  out_free;
   logic                  rsp_load;
   logic                  pick_found;
   logic [IDX_W-1:0]      pick_idx;
   dtt_pkg::pick_ctl_type pick_ctl;

   // input transaction decode
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign slot_ok   = (32'(req_slot) < 32'(SLOTS));
   assign wr_idx    = req_slot[IDX_W-1:0];
   assign req_time  = TIME_BITS'(req_time_value);
   assign mem_we    = req_acc && slot_ok &&
                      ((req_kind == dtt_pkg::KIND_ADD) ||
                       ((req_kind == dtt_pkg::KIND_ADJUST) && armed_ff[wr_idx]));
   assign mem_re    = (state_ff == ST_SCAN) && (cnt_ff < CNT_W'(ENTRIES));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // deadline memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         deadline_mem[wr_idx] <= req_time;
      end
      if (mem_re) begin
         rd_data_ff <= deadline_mem[cnt_ff[IDX_W-1:0]];
      end
   end

   // sequencer: apply requests, scan the table, then hand the previous winner to the output
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rd_vld_in    = mem_re;
      rd_idx_in    = cnt_ff[IDX_W-1:0];
      now_in       = now_ff;
      armed_in     = armed_ff;
      have_prev_in = have_prev_ff;
      prev_slot_in = prev_slot_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_load     = 1'b0;
      pick_ctl     = '{clear: 1'b0, valid: rd_vld_ff, armed: armed_ff[rd_idx_ff]};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_kind == dtt_pkg::KIND_TICK) begin
                  now_in         = req_time;
                  cnt_in         = '0;
                  pick_ctl.clear = 1'b1;
                  state_in       = ST_SCAN;
               end else if (slot_ok) begin
                  if (req_kind == dtt_pkg::KIND_ADD) begin
                     armed_in[wr_idx] = 1'b1;
                  end else if (req_kind == dtt_pkg::KIND_DELETE) begin
                     armed_in[wr_idx] = 1'b0;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (mem_re) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end else if (!rd_vld_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!have_prev_ff || out_free) begin
               rsp_load    = have_prev_ff;
               rsp_slot_in = 6'(prev_slot_ff);
               rsp_last_in = !pick_found;
               if (pick_found) begin
                  armed_in[pick_idx] = 1'b0;
                  prev_slot_in       = pick_idx;
                  have_prev_in       = 1'b1;
                  cnt_in             = '0;
                  pick_ctl.clear     = 1'b1;
                  state_in           = ST_SCAN;
               end else begin
                  have_prev_in = 1'b0;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         armed_ff     <= '0;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         armed_ff     <= armed_in;
         have_prev_ff <= have_prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff    <= rd_idx_in;
      now_ff       <= now_in;
      prev_slot_ff <= prev_slot_in;
      if (rsp_load) begin
         rsp_slot_ff <= rsp_slot_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   // earliest due deadline of the current pass
   dtt_pick #(
      .IDX_W     (IDX_W),
      .TIME_BITS (TIME_BITS)
   ) u_pick (
      .clock    (clock),
      .reset    (reset),
      .ctl      (pick_ctl),
      .idx      (rd_idx_ff),
      .data     (rd_data_ff),
      .now      (now_ff),
      .found    (pick_found),
      .best_idx (pick_idx)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_expired_slot = rsp_slot_ff;
   assign rsp_last         = rsp_last_ff;

   // checks
   a_tick_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_kind == dtt_pkg::KIND_TICK)) |=> (state_ff == ST_SCAN))
      else $error("tick transaction did not start a pass");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !have_prev_ff)
      else $error("pending expired slot left behind in idle");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cnt_ff <= CNT_W'(ENTRIES)))
      else $error("scan counter out of range");

endmodule
